// ----- rtl/mrc_pkg.sv -----
// mrc_pkg: shared constants, codes and types of the modbus rtu response checker
// used by mrc_crc_serial and modbus_rtu_response_checker; no dependencies
package mrc_pkg;

  // default frame capacity in bytes
  localparam int unsigned FRAME_BYTES_DEF = 64;

  // crc-16, reflected form
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // smallest frame: address, function, one byte, two crc bytes
  localparam int unsigned MIN_FRAME = 5;

  // function codes
  localparam logic [7:0] FC_READ_COILS     = 8'h01;
  localparam logic [7:0] FC_READ_DISCRETE  = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT     = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
  localparam logic [7:0] FC_WRITE_REG      = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS     = 8'h10;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_CODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_QUANTITY  = 4'd1;

  // reset values of the configuration registers
  localparam logic [7:0]  FC_RESET = FC_READ_HOLDING;
  localparam logic [15:0] RQ_RESET = 16'h0000;

  // result kinds
  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_COIL   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT = 2'd1;
  localparam logic [1:0] ST_CRC_ERR   = 2'd2;

  // control toward the serial crc unit
  typedef struct packed {
    logic       start;
    logic       clear;
    logic [7:0] data;
  } crc_ctrl_t;

  // status back from the serial crc unit
  typedef struct packed {
    logic        busy;
    logic [15:0] crc;
  } crc_stat_t;

endpackage

// ----- rtl/mrc_crc_serial.sv -----
// mrc_crc_serial: bit-serial crc-16 accumulator, one shift step per cycle
// depends on mrc_pkg for the seed, polynomial and control/status types
module mrc_crc_serial (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrc_pkg::crc_ctrl_t ctrl_i,
  output mrc_pkg::crc_stat_t stat_o
);

  logic [15:0] crc_q, crc_d;
  logic [2:0]  bit_q, bit_d;
  logic        busy_q, busy_d;

  // fold in a byte, then shift it through eight steps
  always_comb begin
    crc_d  = crc_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    if (ctrl_i.clear) begin
      crc_d  = mrc_pkg::CRC_SEED;
      busy_d = 1'b0;
    end else if (ctrl_i.start) begin
      crc_d  = crc_q ^ {8'h00, ctrl_i.data};
      bit_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (crc_q[0]) begin
        crc_d = (crc_q >> 1) ^ mrc_pkg::CRC_POLY;
      end else begin
        crc_d = crc_q >> 1;
      end
      bit_d = bit_q + 3'd1;
      if (bit_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= mrc_pkg::CRC_SEED;
      bit_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      bit_q  <= bit_d;
      busy_q <= busy_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.crc  = crc_q;

endmodule

// ----- rtl/modbus_rtu_response_checker.sv -----
// modbus_rtu_response_checker: top level, frame store, sequencer and output register
// depends on mrc_pkg and mrc_crc_serial
//
// Takes a Modbus RTU response one byte per transaction, stores up to FRAME_BYTES bytes
// and runs a CRC-16 over them in a bit-serial unit. A stored byte is accepted in idle
// and shifted through the CRC unit in S_CRC, and the block returns to idle before the
// next acceptance; a byte past capacity is neither stored nor shifted. On the byte flagged
// last the sequencer checks length and CRC in S_CHECK and takes the byte count in S_HDR,
// then reads the frame store to unpack it: a coil result passes S_COIL_CHK and S_COIL_OUT,
// a 16-bit result S_PAIR_CHK, S_PAIR_HI and S_PAIR_LO, and a final loop test leads to
// S_STATUS for the status result, each result state also waiting for the output register
// to be free. While a byte or frame is being worked on, in_stall_o is high. Configuration
// writes are always taken (cfg_ready_o is high) and must be made while the block is idle.
// The frame store needs no clearing after reset.
module modbus_rtu_response_checker #(
  parameter int unsigned FRAME_BYTES = mrc_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input byte channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          last_byte_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [15:0]                   value_o,
  output logic [3:0]                    valid_bits_o,
  output logic [1:0]                    status_o,
  output logic                          last_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(FRAME_BYTES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRC,
    S_CHECK,
    S_HDR,
    S_COIL_CHK,
    S_COIL_OUT,
    S_PAIR_CHK,
    S_PAIR_HI,
    S_PAIR_LO,
    S_STATUS
  } state_e;

  state_e state_q;

  // configuration registers
  logic [7:0]  func_code_q;
  logic [15:0] req_qty_q;

  // frame bookkeeping
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] ptr_q;
  logic [CNT_W-1:0] end_q;
  logic [15:0]      coils_q;
  logic             fin_q;
  logic [1:0]       stat_code_q;
  logic [7:0]       hi_q;

  // output register
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [15:0] value_q;
  logic [3:0]  vbits_q;
  logic [1:0]  status_q;
  logic        last_q;

  // frame store
  logic [7:0]       mem_q [FRAME_BYTES];
  logic [7:0]       rdata_q;
  logic [IDX_W-1:0] raddr;
  logic             mem_we;

  mrc_pkg::crc_ctrl_t crc_ctrl;
  mrc_pkg::crc_stat_t crc_stat;

  logic             in_fire;
  logic             out_free;
  logic             res_load;
  logic             room;
  logic [CNT_W-1:0] ptr_plus1;
  logic [CNT_W-1:0] avail;
  logic [CNT_W-1:0] byte_cnt;
  logic [15:0]      coil_left;
  logic [3:0]       coil_vb;
  logic [7:0]       coil_mask;
  logic [7:0]       lo_byte;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign room        = (cnt_q < CNT_W'(FRAME_BYTES));
  assign mem_we      = in_fire && room;
  assign ptr_plus1   = ptr_q + CNT_W'(1);
  assign avail       = cnt_q - CNT_W'(mrc_pkg::MIN_FRAME);
  assign cfg_ready_o = 1'b1;

  // a result goes into the output register this cycle
  assign res_load = out_free &&
                    (state_q == S_COIL_OUT || state_q == S_PAIR_LO || state_q == S_STATUS);

  // byte count clamped to the data between header and trailer
  assign byte_cnt = (rdata_q > 8'(avail)) ? avail : CNT_W'(rdata_q);

  // coil bits still owed, capped at one byte
  assign coil_left = (req_qty_q > coils_q) ? (req_qty_q - coils_q) : 16'h0000;
  assign coil_vb   = (coil_left >= 16'd8) ? 4'd8 : coil_left[3:0];
  assign coil_mask = 8'hFF >> (4'd8 - coil_vb);

  // low byte of a pair reads as zero past the stored frame
  assign lo_byte = (ptr_plus1 < cnt_q) ? rdata_q : 8'h00;

  // read address for the store
  always_comb begin
    unique case (state_q)
      S_CHECK:   raddr = IDX_W'(2);
      S_PAIR_HI,
      S_PAIR_LO: raddr = ptr_plus1[IDX_W-1:0];
      default:   raddr = ptr_q[IDX_W-1:0];
    endcase
  end

  // crc unit control
  always_comb begin
    crc_ctrl.start = mem_we;
    crc_ctrl.data  = rx_byte_i;
    crc_ctrl.clear = (state_q == S_STATUS) && out_free;
  end

  mrc_crc_serial u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .stat_o (crc_stat)
  );

  // frame store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[IDX_W-1:0]] <= rx_byte_i;
    end
    rdata_q <= mem_q[raddr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_code_q <= mrc_pkg::FC_RESET;
      req_qty_q   <= mrc_pkg::RQ_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == mrc_pkg::CFG_FUNCTION_CODE) begin
        func_code_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == mrc_pkg::CFG_REQ_QUANTITY) begin
        req_qty_q <= cfg_data_i;
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      coils_q     <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      end_q       <= '0;
      stat_code_q <= mrc_pkg::ST_OK;
      hi_q        <= '0;
      kind_q      <= mrc_pkg::KIND_STATUS;
      value_q     <= '0;
      vbits_q     <= '0;
      status_q    <= mrc_pkg::ST_OK;
      last_q      <= 1'b0;
    end else begin
      // result loaded, or taken downstream
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            fin_q <= last_byte_i;
            if (room) begin
              cnt_q   <= cnt_q + CNT_W'(1);
              state_q <= S_CRC;
            end else if (last_byte_i) begin
              state_q <= S_CHECK;
            end
          end
        end

        S_CRC: begin
          if (!crc_stat.busy) begin
            state_q <= fin_q ? S_CHECK : S_IDLE;
          end
        end

        // length and crc checks; byte count is being read
        S_CHECK: begin
          if (cnt_q < CNT_W'(mrc_pkg::MIN_FRAME)) begin
            stat_code_q <= mrc_pkg::ST_TOO_SHORT;
            state_q     <= S_STATUS;
          end else if (crc_stat.crc != 16'h0000) begin
            stat_code_q <= mrc_pkg::ST_CRC_ERR;
            state_q     <= S_STATUS;
          end else begin
            stat_code_q <= mrc_pkg::ST_OK;
            state_q     <= S_HDR;
          end
        end

        // pick the unpacking path and its end pointer
        S_HDR: begin
          unique case (func_code_q)
            mrc_pkg::FC_READ_COILS,
            mrc_pkg::FC_READ_DISCRETE: begin
              ptr_q   <= CNT_W'(3);
              end_q   <= byte_cnt + CNT_W'(3);
              state_q <= S_COIL_CHK;
            end
            mrc_pkg::FC_READ_HOLDING,
            mrc_pkg::FC_READ_INPUT: begin
              ptr_q   <= CNT_W'(3);
              end_q   <= byte_cnt + CNT_W'(3);
              state_q <= S_PAIR_CHK;
            end
            mrc_pkg::FC_WRITE_COIL,
            mrc_pkg::FC_WRITE_REG,
            mrc_pkg::FC_WRITE_COILS,
            mrc_pkg::FC_WRITE_REGS: begin
              // echo: address pair then value or quantity pair
              ptr_q   <= CNT_W'(2);
              end_q   <= CNT_W'(6);
              state_q <= S_PAIR_CHK;
            end
            default: begin
              state_q <= S_STATUS;
            end
          endcase
        end

        // coil loop: stop at end of data or when the quantity is used up
        S_COIL_CHK: begin
          if (ptr_q < end_q && coil_left != 16'h0000) begin
            state_q <= S_COIL_OUT;
          end else begin
            state_q <= S_STATUS;
          end
        end

        S_COIL_OUT: begin
          if (out_free) begin
            kind_q   <= mrc_pkg::KIND_COIL;
            value_q  <= {8'h00, rdata_q & coil_mask};
            vbits_q  <= coil_vb;
            status_q <= mrc_pkg::ST_OK;
            last_q   <= 1'b0;
            coils_q  <= coils_q + 16'(coil_vb);
            ptr_q    <= ptr_plus1;
            state_q  <= S_COIL_CHK;
          end
        end

        // 16-bit pair loop
        S_PAIR_CHK: begin
          if (ptr_q < end_q) begin
            state_q <= S_PAIR_HI;
          end else begin
            state_q <= S_STATUS;
          end
        end

        S_PAIR_HI: begin
          hi_q    <= (ptr_q < cnt_q) ? rdata_q : 8'h00;
          state_q <= S_PAIR_LO;
        end

        S_PAIR_LO: begin
          if (out_free) begin
            kind_q   <= mrc_pkg::KIND_WORD;
            value_q  <= {hi_q, lo_byte};
            vbits_q  <= 4'd0;
            status_q <= mrc_pkg::ST_OK;
            last_q   <= 1'b0;
            ptr_q    <= ptr_q + CNT_W'(2);
            state_q  <= S_PAIR_CHK;
          end
        end

        // closing status result, then back to an empty frame
        S_STATUS: begin
          if (out_free) begin
            kind_q   <= mrc_pkg::KIND_STATUS;
            value_q  <= 16'h0000;
            vbits_q  <= 4'd0;
            status_q <= stat_code_q;
            last_q   <= 1'b1;
            cnt_q    <= '0;
            coils_q  <= '0;
            state_q  <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign value_o      = value_q;
  assign valid_bits_o = vbits_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule
